@@ rtl/kss_pkg.sv @@
// ----------------------------------------------------------------------------
// kss_pkg
// shared types and constants of the keyed slot store
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int SlotCount = 64;
    localparam int KeyWidth  = 32;
    localparam int ValWidth  = 32;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_BAD_KEY   = 2'd3
    } t_status;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_FREE
    } t_state;

    typedef struct packed {
        logic                operation;
        logic [KeyWidth-1:0] key;
        logic [ValWidth-1:0] value;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [ValWidth-1:0] read_value;
    } t_result;

    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_mem_we;

endpackage

@@ rtl/keyed_slot_store_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_slot_store_unit
// key/value slot table searched by linear scan, key zero marks an empty slot
// ----------------------------------------------------------------------------
// a transaction is taken on i_cmd when start is high and busy is low
// operation get returns the stored value of the key, set stores key and value
// a set frees the key's old slot and takes the next free slot after it
// one result per transaction on o_result, valid for one cycle with o_done
// results cannot be held off; o_done is a single-cycle strobe
// key zero is answered in the cycle after it is taken, without a scan
// a get scans the key memory for the key, a set scans it for the key and
// then once more for a free slot; scans are bounded by the single read
// port of the key memory, which the shared comparator walks one slot per cycle
// after reset the key memory is cleared one slot per cycle with busy high
// value memory is not cleared; values are only read from written slots
// ----------------------------------------------------------------------------
module keyed_slot_store_unit #(
    parameter int SLOT_COUNT = kss_pkg::SlotCount
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  kss_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_done,
    output kss_pkg::t_result o_result
);

    localparam int IW = $clog2(SLOT_COUNT);

    kss_pkg::t_mem_we             we;
    logic [IW-1:0]                wr_addr;
    logic [kss_pkg::KeyWidth-1:0] wr_key;
    logic [kss_pkg::ValWidth-1:0] wr_val;
    logic [IW-1:0]                rd_addr;
    logic [kss_pkg::KeyWidth-1:0] rd_key;
    logic [kss_pkg::ValWidth-1:0] rd_val;

    kss_ctrl #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_we     (we),
        .o_wr_addr(wr_addr),
        .o_wr_key (wr_key),
        .o_wr_val (wr_val),
        .o_rd_addr(rd_addr),
        .i_rd_key (rd_key),
        .i_rd_val (rd_val)
    );

    kss_slot_mem #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_wr_addr(wr_addr),
        .i_wr_key (wr_key),
        .i_wr_val (wr_val),
        .i_rd_addr(rd_addr),
        .o_rd_key (rd_key),
        .o_rd_val (rd_val)
    );

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_bad_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.key == '0)) |=>
            (o_done && (o_result.status == kss_pkg::ST_BAD_KEY) && !busy))
        else $error("key zero not rejected");

    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.key != '0)) |=> (busy && !o_done))
        else $error("scan not started");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != kss_pkg::ST_OK)) |-> (o_result.read_value == '0))
        else $error("value on failed transaction");

endmodule

@@ rtl/kss_slot_mem.sv @@
// ----------------------------------------------------------------------------
// kss_slot_mem
// key and value slot arrays, one write port and one registered read port each
// ----------------------------------------------------------------------------
module kss_slot_mem #(
    parameter int SLOT_COUNT = kss_pkg::SlotCount,
    localparam int IW = $clog2(SLOT_COUNT)
) (
    input  logic                         i_clk,
    input  kss_pkg::t_mem_we             i_we,
    input  logic [IW-1:0]                i_wr_addr,
    input  logic [kss_pkg::KeyWidth-1:0] i_wr_key,
    input  logic [kss_pkg::ValWidth-1:0] i_wr_val,
    input  logic [IW-1:0]                i_rd_addr,
    output logic [kss_pkg::KeyWidth-1:0] o_rd_key,
    output logic [kss_pkg::ValWidth-1:0] o_rd_val
);

    logic [kss_pkg::KeyWidth-1:0] r_key_mem [SLOT_COUNT];
    logic [kss_pkg::ValWidth-1:0] r_val_mem [SLOT_COUNT];
    logic [kss_pkg::KeyWidth-1:0] r_rd_key;
    logic [kss_pkg::ValWidth-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_we.key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        r_rd_val <= r_val_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule

@@ rtl/kss_ctrl.sv @@
// ----------------------------------------------------------------------------
// kss_ctrl
// scan sequencer with one shared key comparator and slot counter
// ----------------------------------------------------------------------------
module kss_ctrl #(
    parameter int SLOT_COUNT = kss_pkg::SlotCount,
    localparam int IW = $clog2(SLOT_COUNT),
    localparam int CW = $clog2(SLOT_COUNT + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  kss_pkg::t_cmd                i_cmd,
    output logic                         busy,
    output logic                         o_done,
    output kss_pkg::t_result             o_result,
    output kss_pkg::t_mem_we             o_we,
    output logic [IW-1:0]                o_wr_addr,
    output logic [kss_pkg::KeyWidth-1:0] o_wr_key,
    output logic [kss_pkg::ValWidth-1:0] o_wr_val,
    output logic [IW-1:0]                o_rd_addr,
    input  logic [kss_pkg::KeyWidth-1:0] i_rd_key,
    input  logic [kss_pkg::ValWidth-1:0] i_rd_val
);

    kss_pkg::t_state              r_state, n_state;
    logic [IW-1:0]                r_ia, n_ia;
    logic [IW-1:0]                r_pa, n_pa;
    logic [CW-1:0]                r_ic, n_ic;
    logic                         r_pv, n_pv;
    logic                         r_op, n_op;
    logic [kss_pkg::KeyWidth-1:0] r_key, n_key;
    logic [kss_pkg::ValWidth-1:0] r_val, n_val;
    logic                         r_done, n_done;
    kss_pkg::t_result             r_res, n_res;

    logic [kss_pkg::KeyWidth-1:0] target;
    logic                         hit;
    logic                         last;
    logic                         accept;
    logic [IW-1:0]                ia_inc;
    logic [IW-1:0]                pa_inc;

    // shared comparator: key during find, empty marker during free search
    assign target = (r_state == kss_pkg::S_FIND) ? r_key : '0;
    assign hit    = r_pv && (i_rd_key == target);
    assign last   = (r_ic == CW'(SLOT_COUNT));
    assign accept = start && !busy;
    assign ia_inc = (r_ia == IW'(SLOT_COUNT - 1)) ? '0 : r_ia + 1'b1;
    assign pa_inc = (r_pa == IW'(SLOT_COUNT - 1)) ? '0 : r_pa + 1'b1;
    assign busy   = (r_state != kss_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kss_pkg::S_CLEAR: begin
                if (r_ia == IW'(SLOT_COUNT - 1)) begin
                    n_state = kss_pkg::S_IDLE;
                end
            end
            kss_pkg::S_IDLE: begin
                if (accept && (i_cmd.key != '0)) begin
                    n_state = kss_pkg::S_FIND;
                end
            end
            kss_pkg::S_FIND: begin
                if (hit || (r_pv && last)) begin
                    n_state = (r_op == kss_pkg::OP_SET) ? kss_pkg::S_FREE : kss_pkg::S_IDLE;
                end
            end
            kss_pkg::S_FREE: begin
                if (hit || (r_pv && last)) begin
                    n_state = kss_pkg::S_IDLE;
                end
            end
            default: n_state = kss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_ia      = r_ia;
        n_pa      = r_pa;
        n_ic      = r_ic;
        n_pv      = r_pv;
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_done    = 1'b0;
        n_res     = r_res;
        o_we      = '0;
        o_wr_addr = r_ia;
        o_wr_key  = '0;
        o_wr_val  = r_val;
        o_rd_addr = r_ia;
        unique case (r_state)
            kss_pkg::S_CLEAR: begin
                o_we.key_we = 1'b1;
                n_ia        = ia_inc;
            end
            kss_pkg::S_IDLE: begin
                if (accept) begin
                    n_op  = i_cmd.operation;
                    n_key = i_cmd.key;
                    n_val = i_cmd.value;
                    n_ia  = '0;
                    n_ic  = '0;
                    n_pv  = 1'b0;
                    if (i_cmd.key == '0) begin
                        n_done = 1'b1;
                        n_res  = '{status: kss_pkg::ST_BAD_KEY, read_value: '0};
                    end
                end
            end
            kss_pkg::S_FIND: begin
                if (hit) begin
                    if (r_op == kss_pkg::OP_GET) begin
                        n_done = 1'b1;
                        n_res  = '{status: kss_pkg::ST_OK, read_value: i_rd_val};
                    end else begin
                        // free the old slot, then search from the next one
                        o_we.key_we = 1'b1;
                        o_wr_addr   = r_pa;
                        n_ia        = pa_inc;
                        n_ic        = '0;
                        n_pv        = 1'b0;
                    end
                end else if (r_pv && last) begin
                    if (r_op == kss_pkg::OP_GET) begin
                        n_done = 1'b1;
                        n_res  = '{status: kss_pkg::ST_NOT_FOUND, read_value: '0};
                    end else begin
                        n_ia = IW'(1);
                        n_ic = '0;
                        n_pv = 1'b0;
                    end
                end else if (!last) begin
                    n_pa = r_ia;
                    n_pv = 1'b1;
                    n_ia = ia_inc;
                    n_ic = r_ic + 1'b1;
                end
            end
            kss_pkg::S_FREE: begin
                if (hit) begin
                    o_we.key_we = 1'b1;
                    o_we.val_we = 1'b1;
                    o_wr_addr   = r_pa;
                    o_wr_key    = r_key;
                    n_done      = 1'b1;
                    n_res       = '{status: kss_pkg::ST_OK, read_value: '0};
                end else if (r_pv && last) begin
                    n_done = 1'b1;
                    n_res  = '{status: kss_pkg::ST_NO_SPACE, read_value: '0};
                end else if (!last) begin
                    n_pa = r_ia;
                    n_pv = 1'b1;
                    n_ia = ia_inc;
                    n_ic = r_ic + 1'b1;
                end
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kss_pkg::S_CLEAR;
            r_ia    <= '0;
            r_ic    <= '0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ia    <= n_ia;
            r_ic    <= n_ic;
            r_pv    <= n_pv;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_op  <= n_op;
        r_key <= n_key;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ test/keyed_slot_store_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_slot_store_unit_tb
// drives get and set transactions into the slot store and checks every result,
// typed rows against their own expected result and all others against a slot
// table kept alongside it; a short table of directed transactions comes first,
// then random traffic over a growing key pool that fills the table, all with
// bursty start and random gaps
module keyed_slot_store_unit_tb;

    typedef struct {
        kss_pkg::t_cmd    cmd;
        bit               typed;
        kss_pkg::t_result want;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    kss_pkg::t_cmd    i_cmd;
    logic             busy;
    logic             o_done;
    kss_pkg::t_result o_result;

    logic [kss_pkg::KeyWidth-1:0] model_keys [kss_pkg::SlotCount];
    logic [kss_pkg::ValWidth-1:0] model_vals [kss_pkg::SlotCount];
    logic [kss_pkg::KeyWidth-1:0] key_pool [96];
    kss_pkg::t_result             pending_results [$];
    t_dir_row                     dir_rows [$];
    kss_pkg::t_result             got_want;
    int                           err_count   = 0;
    int                           burst_left  = 1;
    bit                           no_idle     = 1'b0;

    keyed_slot_store_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic kss_pkg::t_result slot_store_predict(input kss_pkg::t_cmd cmd);
        kss_pkg::t_result r;
        int               hit;
        int               spot;
        r.status     = kss_pkg::ST_OK;
        r.read_value = '0;
        hit          = kss_pkg::SlotCount;
        spot         = kss_pkg::SlotCount;
        if (cmd.key == '0) begin
            r.status = kss_pkg::ST_BAD_KEY;
        end else begin
            for (int i = kss_pkg::SlotCount - 1; i >= 0; i--) begin
                if (model_keys[i] == cmd.key) hit = i;
            end
            if (cmd.operation == kss_pkg::OP_GET) begin
                if (hit < kss_pkg::SlotCount) r.read_value = model_vals[hit];
                else r.status = kss_pkg::ST_NOT_FOUND;
            end else begin
                if (hit < kss_pkg::SlotCount) model_keys[hit] = '0;
                else hit = 0;
                for (int i = kss_pkg::SlotCount - 1; i > hit; i--) begin
                    if (model_keys[i] == '0) spot = i;
                end
                if (spot == kss_pkg::SlotCount) begin
                    for (int i = hit; i >= 0; i--) begin
                        if (model_keys[i] == '0) spot = i;
                    end
                end
                if (spot < kss_pkg::SlotCount) begin
                    model_keys[spot] = cmd.key;
                    model_vals[spot] = cmd.value;
                end else begin
                    r.status = kss_pkg::ST_NO_SPACE;
                end
            end
        end
        return r;
    endfunction

    task automatic add_row(input kss_pkg::t_op op, input logic [31:0] key,
                           input logic [31:0] value, input bit typed,
                           input kss_pkg::t_status st, input logic [31:0] rd);
        t_dir_row row;
        row.cmd.operation     = op;
        row.cmd.key           = key;
        row.cmd.value         = value;
        row.typed             = typed;
        row.want.status       = st;
        row.want.read_value   = rd;
        dir_rows.push_back(row);
    endtask

    task automatic send_cmd(input kss_pkg::t_cmd cmd, input bit typed,
                            input kss_pkg::t_result want);
        kss_pkg::t_result predicted;
        int               gap;
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = slot_store_predict(cmd);
        pending_results.push_back(typed ? want : predicted);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            if (no_idle) gap = 0;
            else if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 140);
            else gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("result with nothing pending: status %0d value %h",
                                     o_result.status, o_result.read_value));
            end else begin
                got_want = pending_results.pop_front();
                if (o_result.status !== got_want.status)
                    note_error($sformatf("status %0d, expected %0d",
                                         o_result.status, got_want.status));
                if (o_result.read_value !== got_want.read_value)
                    note_error($sformatf("read_value %h, expected %h",
                                         o_result.read_value, got_want.read_value));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("keyed_slot_store_unit_tb: errors");
        $finish;
    end

    initial begin
        kss_pkg::t_cmd    cmd;
        kss_pkg::t_result none;
        int               lim;
        int               pick;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        none    = '{kss_pkg::ST_OK, '0};
        for (int i = 0; i < kss_pkg::SlotCount; i++) begin
            model_keys[i] = '0;
            model_vals[i] = '0;
        end
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (int i = 3; i < 96; i++) begin
            do key_pool[i] = $urandom(); while (key_pool[i] == '0);
        end

        // empty table, key zero, store and read back, rewrite of a stored key
        add_row(kss_pkg::OP_GET, 32'h0000_0001, 32'h0,         1,
                kss_pkg::ST_NOT_FOUND, 32'h0);
        add_row(kss_pkg::OP_GET, 32'h0000_0000, 32'h0,         1,
                kss_pkg::ST_BAD_KEY,   32'h0);
        add_row(kss_pkg::OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1,
                kss_pkg::ST_BAD_KEY,   32'h0);
        add_row(kss_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0,         1,
                kss_pkg::ST_OK,        32'hFFFF_FFFF);
        add_row(kss_pkg::OP_SET, 32'h0000_0001, 32'h0,         1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'h0000_0001, 32'hFFFF_FFFF, 1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_SET, 32'h8000_0000, 32'h8000_0000, 1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_SET, 32'hFFFF_FFFF, 32'h1234_5678, 1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0,         0,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1,
                kss_pkg::ST_BAD_KEY,   32'h0);
        add_row(kss_pkg::OP_SET, 32'h0000_0001, 32'hA5A5_A5A5, 1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'h0000_0001, 32'h0,         0,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'hFFFF_FFFE, 32'h0,         1,
                kss_pkg::ST_NOT_FOUND, 32'h0);
        add_row(kss_pkg::OP_GET, 32'h8000_0000, 32'h0,         1,
                kss_pkg::ST_OK,        32'h8000_0000);
        add_row(kss_pkg::OP_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                kss_pkg::ST_OK,        32'h0);
        add_row(kss_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0,         0,
                kss_pkg::ST_OK,        32'h0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        // pool widens past the slot count so the table fills and stays full
        for (int n = 0; n < 2000; n++) begin
            no_idle = (n >= 800 && n < 1100);
            lim     = (n < 1000) ? 8 + n * 88 / 1000 : 95;
            pick    = $urandom_range(0, 99);
            if (pick < 4) cmd.key = '0;
            else if (pick < 7) cmd.key = $urandom();
            else cmd.key = key_pool[$urandom_range(0, lim)];
            cmd.operation = $urandom_range(0, 1) ? kss_pkg::OP_SET : kss_pkg::OP_GET;
            pick = $urandom_range(0, 15);
            if (pick == 0) cmd.value = '0;
            else if (pick == 1) cmd.value = '1;
            else cmd.value = $urandom();
            send_cmd(cmd, 1'b0, none);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * kss_pkg::SlotCount + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("keyed_slot_store_unit_tb: clean");
        end else begin
            $display("keyed_slot_store_unit_tb: errors");
        end
        $finish;
    end

endmodule
